>>> sv/tic_pkg.sv
// ----------------------------------------------------------------------------
// tic_pkg - shared codes and types for the table interpolation converter
// Status codes, operation codes, register indexes and the control word that
// travels with a conversion beat along the row of table cells.
// ----------------------------------------------------------------------------
package tic_pkg;

	// operation carried in tuser of the input beat
	localparam logic OP_CONVERT = 1'b0;
	localparam logic OP_LOAD    = 1'b1;

	// result status
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_ZSPAN = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEAREST_MODE = 1'd1;

	// control word of the conversion token
	typedef struct packed {
		logic valid;     // token present in this cell stage
		logic done;      // a cell has settled the result
		logic interp;    // result lies between the previous and the current pair
		logic has_prev;  // at least one key below the channel value was passed
	} tok_ctl_t;

endpackage

>>> sv/tic_cell.sv
// ----------------------------------------------------------------------------
// tic_cell - one table cell of the scan chain
// Holds one key/value pair, compares the passing channel value with its key
// and hands the updated token, registered, to the next cell.
// ----------------------------------------------------------------------------
module tic_cell #(
	parameter int unsigned W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [W-1:0]         ld_key,
	input  logic [W-1:0]         ld_value,
	input  logic                 active,
	input  tic_pkg::tok_ctl_t    in_ctl,
	input  logic [W-1:0]         in_c,
	input  logic [W-1:0]         in_pk,
	input  logic [W-1:0]         in_pv,
	input  logic [W-1:0]         in_k,
	input  logic [W-1:0]         in_v,
	output tic_pkg::tok_ctl_t    out_ctl,
	output logic [W-1:0]         out_c,
	output logic [W-1:0]         out_pk,
	output logic [W-1:0]         out_pv,
	output logic [W-1:0]         out_k,
	output logic [W-1:0]         out_v
);

	logic [W-1:0]      key_q;
	logic [W-1:0]      value_q;
	tic_pkg::tok_ctl_t ctl_d;
	logic [W-1:0]      pk_d, pv_d, k_d, v_d;

	// stored pair
	always_ff @(posedge clk) begin
		if (load) begin
			key_q   <= ld_key;
			value_q <= ld_value;
		end
	end

	// compare step
	always_comb begin
		ctl_d = in_ctl;
		pk_d  = in_pk;
		pv_d  = in_pv;
		k_d   = in_k;
		v_d   = in_v;
		if (in_ctl.valid && !in_ctl.done && active) begin
			if (in_c == key_q) begin
				ctl_d.done = 1'b1;
				pv_d       = value_q;
			end else if ($signed(in_c) < $signed(key_q)) begin
				ctl_d.done = 1'b1;
				if (!in_ctl.has_prev) begin
					// below the first key: first value
					pv_d = value_q;
				end else begin
					ctl_d.interp = 1'b1;
					k_d          = key_q;
					v_d          = value_q;
				end
			end else begin
				ctl_d.has_prev = 1'b1;
				pk_d           = key_q;
				pv_d           = value_q;
			end
		end
	end

	// token control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl <= '0;
		end else begin
			out_ctl <= ctl_d;
		end
	end

	// token data
	always_ff @(posedge clk) begin
		out_c  <= in_c;
		out_pk <= pk_d;
		out_pv <= pv_d;
		out_k  <= k_d;
		out_v  <= v_d;
	end

endmodule

>>> sv/tic_muldiv.sv
// ----------------------------------------------------------------------------
// tic_muldiv - sequential multiply then divide
// Forms a*b by shift and add, one bit a cycle, then divides the product by d
// with a restoring divider, one quotient bit a cycle. Needs a < d so that the
// quotient fits W bits. done stays high until the next start.
// ----------------------------------------------------------------------------
module tic_muldiv #(
	parameter int unsigned W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] d,
	output logic         done,
	output logic [W-1:0] q
);

	localparam int unsigned CW = $clog2(W);

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_MUL  = 3'b010,
		M_DIV  = 3'b100
	} md_state_t;

	md_state_t       state_q;
	logic [CW-1:0]   cnt_q;
	logic            done_q;
	logic [W-1:0]    a_q, b_q, d_q;
	logic [W-1:0]    hi_q, lo_q;
	logic [2*W-1:0]  prod_nxt;
	logic [W:0]      sh;
	logic [W:0]      diff;
	logic            ge;
	logic [W-1:0]    rem_nxt;
	logic            last;

	// shift-add step
	assign prod_nxt = {hi_q[W-2:0], lo_q, 1'b0} + (a_q[W-1] ? {{W{1'b0}}, b_q} : '0);

	// restoring divide step
	assign sh      = {hi_q, lo_q[W-1]};
	assign diff    = sh - {1'b0, d_q};
	assign ge      = sh >= {1'b0, d_q};
	assign rem_nxt = ge ? diff[W-1:0] : sh[W-1:0];
	assign last    = cnt_q == CW'(W - 1);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
						cnt_q   <= '0;
						done_q  <= 1'b0;
					end
				end
				M_MUL: begin
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					if (last) state_q <= M_DIV;
				end
				M_DIV: begin
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					if (last) begin
						state_q <= M_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (start) begin
					a_q  <= a;
					b_q  <= b;
					d_q  <= d;
					hi_q <= '0;
					lo_q <= '0;
				end
			end
			M_MUL: begin
				{hi_q, lo_q} <= prod_nxt;
				a_q          <= {a_q[W-2:0], 1'b0};
			end
			M_DIV: begin
				hi_q <= rem_nxt;
				lo_q <= {lo_q[W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign q    = lo_q;

endmodule

>>> sv/table_interpolation_conversion_top.sv
// ----------------------------------------------------------------------------
// table_interpolation_conversion_top - piecewise linear table converter
// Loads ascending key/value pairs and converts raw channel values to
// engineering values by exact match, clamping, linear interpolation or
// nearest-value selection.
// ----------------------------------------------------------------------------
// Usage:
//  Input beats on s_axis: tuser selects load (1) or convert (0). A load beat
//  writes one pair and gives no result. A convert beat gives one result beat
//  on m_axis: tdata carries the value, tuser the status (ok, empty table,
//  zero key span).
//  A convert beat walks the row of TABLE_DEPTH cells, one cell a cycle; the
//  token is then captured at the end of the row and the result evaluated.
//  Linear interpolation adds a pass through the shift-add multiplier and
//  the restoring divider before the result is loaded.
//  One conversion is in flight at a time; s_axis_tready is high whenever no
//  conversion is under way, also while a result waits on m_axis.
//  When m_axis stalls, the finished result is held and a following
//  conversion waits at its end until the output register is free.
//  Reset clears the configuration registers (no pairs in use, linear mode)
//  and the handshake state; table contents are undefined until loaded.
//  The user must write configuration (cfg_we/cfg_index/cfg_data) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module table_interpolation_conversion_top #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned DATA_WIDTH  = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration write port
	input  logic                                   cfg_we,
	input  logic [tic_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]       cfg_data,
	// input stream
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// tdata: entry_index, entry_key, entry_value, channel sample, zero pad
	input  logic [(($clog2(TABLE_DEPTH)+3*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// tuser: op
	input  logic                                   s_axis_tuser,
	// output stream
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// tdata: converted value, zero pad
	output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
	// tuser: status
	output logic [1:0]                             m_axis_tuser
);

	localparam int unsigned W     = DATA_WIDTH;
	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_EVAL = 4'b0100,
		S_DIV  = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   entry_count_q;
	logic               nearest_q;
	logic [CNT_W-1:0]   count_eff;

	logic               in_acc;
	logic               in_op;
	logic [IDX_W-1:0]   in_index;
	logic [W-1:0]       in_key, in_value, in_chan;

	// token chain between cells
	tic_pkg::tok_ctl_t  ctl_c [0:TABLE_DEPTH];
	logic [W-1:0]       c_c   [0:TABLE_DEPTH];
	logic [W-1:0]       pk_c  [0:TABLE_DEPTH];
	logic [W-1:0]       pv_c  [0:TABLE_DEPTH];
	logic [W-1:0]       k_c   [0:TABLE_DEPTH];
	logic [W-1:0]       v_c   [0:TABLE_DEPTH];

	// captured tail of the scan
	logic               fin_done_q, fin_interp_q;
	logic [W:0]         span_q, off_q, dv_q;
	logic [W-1:0]       pv_q, v_q;

	logic               zspan;
	logic               pick_lower;
	logic [W-1:0]       dv_mag;
	logic               md_start, md_done;
	logic [W-1:0]       md_q;

	logic               out_free;
	logic               out_load;
	logic [W-1:0]       out_eng_d;
	logic [1:0]         out_stat_d;
	logic               out_valid_q;
	logic [W-1:0]       eng_q;
	logic [1:0]         stat_q;

	// input beat unpacking
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign in_op    = s_axis_tuser;
	assign in_index = s_axis_tdata[IDX_W-1:0];
	assign in_key   = s_axis_tdata[IDX_W +: W];
	assign in_value = s_axis_tdata[IDX_W+W +: W];
	assign in_chan  = s_axis_tdata[IDX_W+2*W +: W];

	assign s_axis_tready = state_q == S_IDLE;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			nearest_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tic_pkg::REG_ENTRY_COUNT:  entry_count_q <= cfg_data;
				tic_pkg::REG_NEAREST_MODE: nearest_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pairs in use, clamped to the table depth
	assign count_eff = (entry_count_q > CNT_W'(TABLE_DEPTH)) ?
		CNT_W'(TABLE_DEPTH) : entry_count_q;

	// token injection at the head of the row
	always_comb begin
		ctl_c[0]       = '0;
		ctl_c[0].valid = in_acc && (in_op == tic_pkg::OP_CONVERT);
		c_c[0]         = in_chan;
		pk_c[0]        = '0;
		pv_c[0]        = '0;
		k_c[0]         = '0;
		v_c[0]         = '0;
	end

	// row of table cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		tic_cell #(
			.W(W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (in_acc && (in_op == tic_pkg::OP_LOAD) && (in_index == IDX_W'(i))),
			.ld_key   (in_key),
			.ld_value (in_value),
			.active   (count_eff > CNT_W'(i)),
			.in_ctl   (ctl_c[i]),
			.in_c     (c_c[i]),
			.in_pk    (pk_c[i]),
			.in_pv    (pv_c[i]),
			.in_k     (k_c[i]),
			.in_v     (v_c[i]),
			.out_ctl  (ctl_c[i+1]),
			.out_c    (c_c[i+1]),
			.out_pk   (pk_c[i+1]),
			.out_pv   (pv_c[i+1]),
			.out_k    (k_c[i+1]),
			.out_v    (v_c[i+1])
		);
	end

	// capture of the token at the end of the row, differences formed here
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && ctl_c[TABLE_DEPTH].valid) begin
			fin_done_q   <= ctl_c[TABLE_DEPTH].done;
			fin_interp_q <= ctl_c[TABLE_DEPTH].interp;
			span_q <= {k_c[TABLE_DEPTH][W-1], k_c[TABLE_DEPTH]}
				- {pk_c[TABLE_DEPTH][W-1], pk_c[TABLE_DEPTH]};
			off_q  <= {c_c[TABLE_DEPTH][W-1], c_c[TABLE_DEPTH]}
				- {pk_c[TABLE_DEPTH][W-1], pk_c[TABLE_DEPTH]};
			dv_q   <= {v_c[TABLE_DEPTH][W-1], v_c[TABLE_DEPTH]}
				- {pv_c[TABLE_DEPTH][W-1], pv_c[TABLE_DEPTH]};
			pv_q   <= pv_c[TABLE_DEPTH];
			v_q    <= v_c[TABLE_DEPTH];
		end
	end

	// span checks and nearest choice (fraction of one half or less: lower)
	assign zspan      = span_q[W] || (span_q == '0) || off_q[W];
	assign pick_lower = {off_q[W-1:0], 1'b0} <= {1'b0, span_q[W-1:0]};
	assign dv_mag     = dv_q[W] ? W'(-dv_q) : dv_q[W-1:0];

	tic_muldiv #(
		.W(W)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.a      (off_q[W-1:0]),
		.b      (dv_mag),
		.d      (span_q[W-1:0]),
		.done   (md_done),
		.q      (md_q)
	);

	assign out_free = !out_valid_q || m_axis_tready;

	// conversion sequencer
	always_comb begin
		state_d    = state_q;
		md_start   = 1'b0;
		out_load   = 1'b0;
		out_eng_d  = pv_q;
		out_stat_d = tic_pkg::STAT_OK;
		case (state_q)
			S_IDLE: begin
				if (in_acc && (in_op == tic_pkg::OP_CONVERT)) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (ctl_c[TABLE_DEPTH].valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				if (count_eff == '0) begin
					out_eng_d  = '0;
					out_stat_d = tic_pkg::STAT_EMPTY;
					out_load   = out_free;
				end else if (!(fin_done_q && fin_interp_q)) begin
					// exact match, below first key or above last key
					out_load = out_free;
				end else if (zspan) begin
					out_eng_d  = '0;
					out_stat_d = tic_pkg::STAT_ZSPAN;
					out_load   = out_free;
				end else if (nearest_q) begin
					out_eng_d = pick_lower ? pv_q : v_q;
					out_load  = out_free;
				end else begin
					md_start = 1'b1;
					state_d  = S_DIV;
				end
				if (out_load) state_d = S_IDLE;
			end
			S_DIV: begin
				// quotient is below |dv|, so the sum stays between the two values
				out_eng_d = dv_q[W] ? pv_q - md_q : pv_q + md_q;
				if (md_done && out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			eng_q  <= out_eng_d;
			stat_q <= out_stat_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(eng_q);
	assign m_axis_tuser  = stat_q;

endmodule
